>>> rtl/cidf_pkg.sv
`timescale 1ns / 1ps
package cidf_pkg;

	// Field widths of the streams.
	localparam int ID_W        = 29;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 6;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 16;

	// Default list depth.
	localparam int DEFAULT_MAX_ENTRIES = 32;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_CHECK  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_DUP     = 2'd2,
		STATUS_MISSING = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} cidf_state_t;

endpackage

>>> rtl/cidf_ram.sv
`timescale 1ns / 1ps
module cidf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/can_id_allow_deny_filter_top.sv
`timescale 1ns / 1ps
// CAN identifier allow/deny filter. Each input transaction carries one operation
// (check, add, remove or clear) on a 29-bit identifier and yields exactly one
// result transaction with the accept flag, a status code and the entry count
// after the operation. The list lives in a single-port-write, single-port-read
// RAM that a small sequencer walks one entry per cycle: check and add walk the
// listed entries (the walk stops early on a match), remove adds one more walk
// over the entries behind the match to close the gap, and clear or an add to a
// full list skips the walk. The block takes no new input while an operation is
// in progress; a finished result sits in an output register until the consumer
// takes it. The mode register may be written only while the block is idle and
// takes effect from the next check.
module can_id_allow_deny_filter_top
	import cidf_pkg::*;
#(
	parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Mode register write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	// Operations: [1:0] operation, [30:2] can_id, [31] zero.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Results: [0] accepted, [2:1] status, [8:3] entry_count, [15:9] zero.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int PAD_W = M_TDATA_W - 1 - STATUS_W - COUNT_OUT_W;

	cidf_state_t state_q, state_d;

	logic             allow_list_mode_q;
	op_t              op_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] issue_idx_q;
	logic             pend_s1;
	logic [CNT_W-1:0] pend_idx_s1;
	logic             res_accepted_q;
	status_t          res_status_q;
	logic             m_tvalid_q;
	logic             out_accepted_q;
	status_t          out_status_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	op_t              in_op;
	logic             list_full;
	logic             rd_en;
	logic [ID_W-1:0]  rd_data;
	logic             hit;
	logic             walk_end;
	logic             out_free;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ID_W-1:0]  wr_data;
	logic [CNT_W-1:0] shift_dst;

	assign in_op     = op_t'(s_tdata[OP_W-1:0]);
	assign list_full = (used_q >= CNT_W'(MAX_ENTRIES));
	assign hit       = pend_s1 && (rd_data == id_q);
	assign walk_end  = !pend_s1 && (issue_idx_q >= used_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign shift_dst = pend_idx_s1 - CNT_W'(1);
	assign rd_en     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) &&
	                   (issue_idx_q < used_q);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{PAD_W{1'b0}}, out_count_q, out_status_q, out_accepted_q};

	// Identifier list storage.
	cidf_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_ENTRIES)
	) u_id_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (issue_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM write control.
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = used_q[IDX_W-1:0];
		wr_data = id_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_op == OP_CLEAR || (in_op == OP_ADD && list_full)) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit || walk_end) begin
					if (op_q == OP_REMOVE && hit) begin
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_FINISH;
					end
					// Append a new identifier at the end of the list.
					if (op_q == OP_ADD && !hit) begin
						wr_en = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				// Each entry read behind the gap is written one place lower.
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = shift_dst[IDX_W-1:0];
					wr_data = rd_data;
				end
				if (walk_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_list_mode_q <= 1'b0;
			used_q            <= '0;
			pend_s1           <= 1'b0;
			m_tvalid_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				allow_list_mode_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (s_tvalid && in_op == OP_CLEAR) begin
						used_q <= '0;
					end
				end
				ST_SCAN: begin
					pend_s1 <= rd_en && !hit;
					if (hit || walk_end) begin
						pend_s1 <= 1'b0;
						if (op_q == OP_ADD && !hit) begin
							used_q <= used_q + CNT_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					pend_s1 <= rd_en;
					if (walk_end) begin
						used_q <= used_q - CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
					end
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Operation, walk pointer and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_q           <= in_op;
					id_q           <= s_tdata[OP_W +: ID_W];
					issue_idx_q    <= '0;
					res_accepted_q <= 1'b0;
					res_status_q   <= (in_op == OP_ADD && list_full) ? STATUS_FULL : STATUS_OK;
				end
			end
			ST_SCAN: begin
				if (rd_en) begin
					issue_idx_q <= issue_idx_q + CNT_W'(1);
					pend_idx_s1 <= issue_idx_q;
				end
				if (hit || walk_end) begin
					case (op_q)
						OP_CHECK: begin
							res_accepted_q <= allow_list_mode_q ? hit : !hit;
						end
						OP_ADD: begin
							if (hit) begin
								res_status_q <= STATUS_DUP;
							end
						end
						OP_REMOVE: begin
							if (hit) begin
								issue_idx_q <= pend_idx_s1 + CNT_W'(1);
							end else begin
								res_status_q <= STATUS_MISSING;
							end
						end
						default: begin
							res_status_q <= STATUS_OK;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (rd_en) begin
					issue_idx_q <= issue_idx_q + CNT_W'(1);
					pend_idx_s1 <= issue_idx_q;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_accepted_q <= res_accepted_q;
					out_status_q   <= res_status_q;
					out_count_q    <= COUNT_OUT_W'(used_q);
				end
			end
			default: begin
				issue_idx_q <= '0;
			end
		endcase
	end

endmodule
